// ----- rtl/core/bptc_pkg.sv -----
package bptc_pkg;

    localparam int RAW_W     = 24;
    localparam int COEF_W    = 16;
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;

    localparam int TC_W = 19;
    localparam int TT_W = 16;
    localparam int PC_W = 32;

    localparam int DT_W   = 25;
    localparam int MUL_W  = 42;
    localparam int DD_W   = 50;
    localparam int QT_W   = 18;
    localparam int QO_W   = 34;
    localparam int QS_W   = 33;
    localparam int T2_W   = 17;
    localparam int AA_W   = 35;
    localparam int A5_W   = 38;
    localparam int OFF_W  = 38;
    localparam int SENS_W = 38;
    localparam int SPLIT  = 19;
    localparam int PL_W   = 43;
    localparam int PH_W   = 44;
    localparam int PP_W   = 62;
    localparam int PD_W   = 41;
    localparam int DF_W   = 42;
    localparam int PQ_W   = 27;
    localparam int TQ_W   = 38;

    localparam int TREF_SH = 8;
    localparam int OFF_SH  = 16;
    localparam int SENS_SH = 15;
    localparam int TSH     = 23;
    localparam int OSH     = 7;
    localparam int SSH     = 8;
    localparam int DSH     = 31;
    localparam int PSH     = 21;
    localparam int QSH     = 15;

    localparam logic signed [TC_W-1:0] TEMP_REF = TC_W'(2000);
    localparam logic [TC_W-1:0]        RECIP10  = TC_W'(419431);
    localparam int                     RECIP_SH = 22;

    localparam logic [CFG_IDX_W-1:0] REG_SENS   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OFF    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TCS    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_TCO    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_TREF   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_TSLOPE = CFG_IDX_W'(5);

    typedef struct packed {
        logic [COEF_W-1:0] sens;
        logic [COEF_W-1:0] off;
        logic [COEF_W-1:0] tcs;
        logic [COEF_W-1:0] tco;
        logic [COEF_W-1:0] tref;
        logic [COEF_W-1:0] tslope;
    } t_cal;

    typedef struct packed {
        logic [TC_W-1:0]   temp;
        logic [OFF_W-1:0]  off;
        logic [SENS_W-1:0] sens;
        logic [RAW_W-1:0]  raw_p;
    } t_comp;

endpackage

// ----- rtl/core/bptc_in_if.sv -----
interface bptc_in_if;
    import bptc_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

// ----- rtl/core/bptc_out_if.sv -----
interface bptc_out_if;
    import bptc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [TC_W-1:0] temp_centi;
    logic signed [TT_W-1:0] temp_tenths;
    logic signed [PC_W-1:0] pressure_centi_mbar;

    modport source (output valid, output temp_centi, output temp_tenths,
                    output pressure_centi_mbar, input ready);
    modport sink   (input valid, input temp_centi, input temp_tenths,
                    input pressure_centi_mbar, output ready);
endinterface

// ----- rtl/core/bptc_comp.sv -----
module bptc_comp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bptc_pkg::t_cal  i_cal,
    bptc_in_if.sink         i_sample,
    output logic            o_valid,
    input  logic            i_ready,
    output bptc_pkg::t_comp o_comp
);
    import bptc_pkg::*;

    localparam int NSTG = 6;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !r_v[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_sample.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_sample.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: temperature difference
    logic signed [DT_W-1:0] r1_dt;
    logic [RAW_W-1:0]       r1_p;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_dt <= $signed({1'b0, i_sample.raw_temperature})
                   - $signed({1'b0, i_cal.tref, {TREF_SH{1'b0}}});
            r1_p  <= i_sample.raw_pressure;
        end
    end

    // stage 2: products of the difference
    logic signed [MUL_W-1:0] w_dt_x;
    logic signed [MUL_W-1:0] w_slope_x;
    logic signed [MUL_W-1:0] w_tco_x;
    logic signed [MUL_W-1:0] w_tcs_x;
    logic signed [DD_W-1:0]  w_dt_d;
    logic signed [MUL_W-1:0] r2_pt;
    logic signed [MUL_W-1:0] r2_po;
    logic signed [MUL_W-1:0] r2_ps;
    logic signed [DD_W-1:0]  r2_dd;
    logic [RAW_W-1:0]        r2_p;

    assign w_dt_x    = MUL_W'(r1_dt);
    assign w_dt_d    = DD_W'(r1_dt);
    assign w_slope_x = $signed({{(MUL_W-COEF_W){1'b0}}, i_cal.tslope});
    assign w_tco_x   = $signed({{(MUL_W-COEF_W){1'b0}}, i_cal.tco});
    assign w_tcs_x   = $signed({{(MUL_W-COEF_W){1'b0}}, i_cal.tcs});

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_pt <= w_dt_x * w_slope_x;
            r2_po <= w_dt_x * w_tco_x;
            r2_ps <= w_dt_x * w_tcs_x;
            r2_dd <= w_dt_d * w_dt_d;
            r2_p  <= r1_p;
        end
    end

    // stage 3: quotients rounded toward zero
    logic [MUL_W-1:0]       w_pt_b;
    logic [MUL_W-1:0]       w_po_b;
    logic [MUL_W-1:0]       w_ps_b;
    logic signed [QT_W-1:0] r3_qt;
    logic signed [QO_W-1:0] r3_qo;
    logic signed [QS_W-1:0] r3_qs;
    logic [T2_W-1:0]        r3_t2;
    logic [RAW_W-1:0]       r3_p;

    assign w_pt_b = r2_pt + {{(MUL_W-TSH){1'b0}}, {TSH{r2_pt[MUL_W-1]}}};
    assign w_po_b = r2_po + {{(MUL_W-OSH){1'b0}}, {OSH{r2_po[MUL_W-1]}}};
    assign w_ps_b = r2_ps + {{(MUL_W-SSH){1'b0}}, {SSH{r2_ps[MUL_W-1]}}};

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_qt <= w_pt_b[TSH+QT_W-1:TSH];
            r3_qo <= w_po_b[OSH+QO_W-1:OSH];
            r3_qs <= w_ps_b[SSH+QS_W-1:SSH];
            r3_t2 <= r2_dd[DSH+T2_W-1:DSH];
            r3_p  <= r2_p;
        end
    end

    // stage 4: first-order values, square of the cold deviation
    logic signed [2*QT_W-1:0] w_qt_x;
    logic signed [2*QT_W-1:0] w_qt_sq;
    logic signed [TC_W-1:0]   r4_temp1;
    logic signed [OFF_W-1:0]  r4_off1;
    logic signed [SENS_W-1:0] r4_sens1;
    logic [AA_W-1:0]          r4_aa;
    logic                     r4_cold;
    logic [T2_W-1:0]          r4_t2;
    logic [RAW_W-1:0]         r4_p;

    assign w_qt_x  = (2*QT_W)'(r3_qt);
    assign w_qt_sq = w_qt_x * w_qt_x;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_temp1 <= TEMP_REF + TC_W'(r3_qt);
            r4_off1  <= OFF_W'({i_cal.off, {OFF_SH{1'b0}}}) + OFF_W'(r3_qo);
            r4_sens1 <= SENS_W'({i_cal.sens, {SENS_SH{1'b0}}}) + SENS_W'(r3_qs);
            r4_aa    <= w_qt_sq[AA_W-1:0];
            r4_cold  <= r3_qt[QT_W-1];
            r4_t2    <= r3_t2;
            r4_p     <= r3_p;
        end
    end

    // stage 5: second-order offset and sensitivity terms
    logic [A5_W-1:0]          w_a5;
    logic [A5_W-2:0]          r5_offc;
    logic [A5_W-3:0]          r5_sensc;
    logic signed [TC_W-1:0]   r5_temp1;
    logic signed [OFF_W-1:0]  r5_off1;
    logic signed [SENS_W-1:0] r5_sens1;
    logic                     r5_cold;
    logic [T2_W-1:0]          r5_t2;
    logic [RAW_W-1:0]         r5_p;

    assign w_a5 = A5_W'({r4_aa, 2'b00}) + A5_W'(r4_aa);

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r5_offc  <= w_a5[A5_W-1:1];
            r5_sensc <= w_a5[A5_W-1:2];
            r5_temp1 <= r4_temp1;
            r5_off1  <= r4_off1;
            r5_sens1 <= r4_sens1;
            r5_cold  <= r4_cold;
            r5_t2    <= r4_t2;
            r5_p     <= r4_p;
        end
    end

    // stage 6: apply cold correction
    logic signed [TC_W-1:0]   r6_temp;
    logic signed [OFF_W-1:0]  r6_off;
    logic signed [SENS_W-1:0] r6_sens;
    logic [RAW_W-1:0]         r6_p;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r6_temp <= r5_cold ? (r5_temp1 - TC_W'(r5_t2)) : r5_temp1;
            r6_off  <= r5_cold ? (r5_off1 - OFF_W'(r5_offc)) : r5_off1;
            r6_sens <= r5_cold ? (r5_sens1 - SENS_W'(r5_sensc)) : r5_sens1;
            r6_p    <= r5_p;
        end
    end

    assign o_valid      = r_v[NSTG-1];
    assign o_comp.temp  = r6_temp;
    assign o_comp.off   = r6_off;
    assign o_comp.sens  = r6_sens;
    assign o_comp.raw_p = r6_p;

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_sample.ready |-> &r_v)
        else $error("input held off while a stage is empty");

    a_cold_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] && r4_cold |-> r4_temp1 < TEMP_REF)
        else $error("cold flag set at or above reference temperature");

    a_cold_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[3] && r4_cold |-> r4_aa != '0)
        else $error("cold item with zero squared deviation");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NSTG-1] && !i_ready |=> r_v[NSTG-1])
        else $error("stalled item dropped");

endmodule

// ----- rtl/core/bptc_fin.sv -----
module bptc_fin (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bptc_pkg::t_comp i_comp,
    bptc_out_if.source      o_result
);
    import bptc_pkg::*;

    localparam int NSTG = 5;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !r_v[NSTG-1] || o_result.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 7: split pressure product, temperature magnitude
    logic signed [PH_W-1:0]  w_p_h;
    logic signed [PH_W-1:0]  w_sh;
    logic [TC_W-1:0]         w_mag;
    logic [PL_W-1:0]         r7_pl;
    logic signed [PH_W-1:0]  r7_ph;
    logic [TC_W-1:0]         r7_mag;
    logic                    r7_neg;
    logic signed [OFF_W-1:0] r7_off;
    logic [TC_W-1:0]         r7_temp;

    assign w_p_h = PH_W'($signed({1'b0, i_comp.raw_p}));
    assign w_sh  = PH_W'($signed(i_comp.sens[SENS_W-1:SPLIT]));
    assign w_mag = i_comp.temp[TC_W-1] ? (~i_comp.temp + TC_W'(1)) : i_comp.temp;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r7_pl   <= PL_W'(i_comp.raw_p) * PL_W'(i_comp.sens[SPLIT-1:0]);
            r7_ph   <= w_p_h * w_sh;
            r7_mag  <= w_mag;
            r7_neg  <= i_comp.temp[TC_W-1];
            r7_off  <= i_comp.off;
            r7_temp <= i_comp.temp;
        end
    end

    // stage 8: join partial products, reciprocal multiply by one tenth
    logic [PP_W-1:0]         r8_prod;
    logic [TQ_W-1:0]         r8_tq;
    logic                    r8_neg;
    logic signed [OFF_W-1:0] r8_off;
    logic [TC_W-1:0]         r8_temp;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r8_prod <= (PP_W'(r7_ph) << SPLIT) + PP_W'(r7_pl);
            r8_tq   <= TQ_W'(r7_mag) * TQ_W'(RECIP10);
            r8_neg  <= r7_neg;
            r8_off  <= r7_off;
            r8_temp <= r7_temp;
        end
    end

    // stage 9: scale product toward zero, sign the tenths
    logic [PP_W-1:0]         w_pb;
    logic [TT_W-1:0]         w_tq;
    logic signed [PD_W-1:0]  r9_pd;
    logic [TT_W-1:0]         r9_tt;
    logic                    r9_neg;
    logic signed [OFF_W-1:0] r9_off;
    logic [TC_W-1:0]         r9_temp;

    assign w_pb = r8_prod + {{(PP_W-PSH){1'b0}}, {PSH{r8_prod[PP_W-1]}}};
    assign w_tq = r8_tq[RECIP_SH+TT_W-1:RECIP_SH];

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r9_pd   <= w_pb[PSH+PD_W-1:PSH];
            r9_tt   <= r8_neg ? (~w_tq + TT_W'(1)) : w_tq;
            r9_neg  <= r8_neg;
            r9_off  <= r8_off;
            r9_temp <= r8_temp;
        end
    end

    // stage 10: remove offset
    logic signed [DF_W-1:0] r10_df;
    logic [TT_W-1:0]        r10_tt;
    logic [TC_W-1:0]        r10_temp;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r10_df   <= DF_W'(r9_pd) - DF_W'(r9_off);
            r10_tt   <= r9_tt;
            r10_temp <= r9_temp;
        end
    end

    // stage 11: final scale toward zero, output register
    logic [DF_W-1:0]        w_db;
    logic signed [PQ_W-1:0] w_pq;
    logic [PC_W-1:0]        r11_pc;
    logic [TT_W-1:0]        r11_tt;
    logic [TC_W-1:0]        r11_temp;

    assign w_db = r10_df + {{(DF_W-QSH){1'b0}}, {QSH{r10_df[DF_W-1]}}};
    assign w_pq = w_db[QSH+PQ_W-1:QSH];

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r11_pc   <= PC_W'(w_pq);
            r11_tt   <= r10_tt;
            r11_temp <= r10_temp;
        end
    end

    assign o_result.valid               = r_v[NSTG-1];
    assign o_result.temp_centi          = r11_temp;
    assign o_result.temp_tenths         = r11_tt;
    assign o_result.pressure_centi_mbar = r11_pc;

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> &r_v)
        else $error("upstream held off while a stage is empty");

    a_tenths_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NSTG-1] |-> (o_result.temp_centi[TC_W-1] == o_result.temp_tenths[TT_W-1])
                        || (o_result.temp_tenths == '0))
        else $error("tenths sign disagrees with centi temperature");

    a_pos_tenths: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] && !r9_neg |-> !r9_tt[TT_W-1])
        else $error("non-negative temperature gave negative tenths");

endmodule

// ----- rtl/core/baro_pressure_temp_compensation.sv -----
// Compensates raw 24-bit pressure and temperature conversions with six 16-bit
// calibration words, giving temperature in 0.01 C and 0.1 C and pressure in
// 0.01 mbar, with the second-order correction below 20.00 C. One item is
// accepted every clock unless all stages are full and the output stalls.
// Stages follow the multiply chain (difference products, squared cold
// deviation, split 24x38 pressure product, reciprocal divide by ten), one
// multiplier deep per stage. Every stage moves independently, so a stalled
// output only holds back input once all 11 stages hold items.
// Calibration registers reset to zero and are written through
// i_cfg_we/i_cfg_idx/i_cfg_data, by the user only while no item is in flight
// (not enforced by the block); indexes beyond the sixth register are ignored.
module baro_pressure_temp_compensation (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bptc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bptc_pkg::COEF_W-1:0]         i_cfg_data,
    bptc_in_if.sink                             i_sample,
    bptc_out_if.source                          o_result
);
    import bptc_pkg::*;

    t_cal  r_cal;
    logic  w_mid_valid;
    logic  w_mid_ready;
    t_comp w_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SENS:   r_cal.sens   <= i_cfg_data;
                REG_OFF:    r_cal.off    <= i_cfg_data;
                REG_TCS:    r_cal.tcs    <= i_cfg_data;
                REG_TCO:    r_cal.tco    <= i_cfg_data;
                REG_TREF:   r_cal.tref   <= i_cfg_data;
                REG_TSLOPE: r_cal.tslope <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bptc_comp u_comp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cal    (r_cal),
        .i_sample (i_sample),
        .o_valid  (w_mid_valid),
        .i_ready  (w_mid_ready),
        .o_comp   (w_mid)
    );

    bptc_fin u_fin (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_mid_valid),
        .o_ready  (w_mid_ready),
        .i_comp   (w_mid),
        .o_result (o_result)
    );

endmodule

// ----- dv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bptc_pkg::*;

    localparam int PIPE_DEPTH   = 11;
    localparam int RANDOM_ITEMS = 700;
    localparam int PHASES       = 7;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);

    localparam longint ROOM_CENTI = 2000;
    localparam logic [RAW_W-1:0] RAW_MAX = '1;
    localparam logic [COEF_W-1:0] COEF_MAX = '1;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_SLOW
    } t_rx_mode;

    typedef struct {
        logic signed [TC_W-1:0] temp_centi;
        logic signed [TT_W-1:0] temp_tenths;
        logic signed [PC_W-1:0] pressure_centi_mbar;
        bit                     cold;
    } t_reading;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COEF_W-1:0]    i_cfg_data;

    bptc_in_if  sample_if ();
    bptc_out_if result_if ();

    baro_pressure_temp_compensation u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (sample_if),
        .o_result   (result_if)
    );

    logic [COEF_W-1:0] cal [NUM_REGS];
    t_reading          pending_readings [$];
    t_rx_mode          rx_mode = RX_ALWAYS;
    int unsigned       rx_tick = 0;
    int                n_err = 0;
    int                n_checked = 0;
    int                n_sent = 0;
    int                n_cold = 0;
    int                n_cal_sets = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_reading compensate(input logic [RAW_W-1:0] p_raw, t_raw);
        longint   d1, d2, c_sens, c_off, c_tcs, c_tco, c_tref, c_tslope;
        longint   dt, temp, off, sens, dev, aux, press, tenths;
        t_reading r;
        d1       = longint'(p_raw);
        d2       = longint'(t_raw);
        c_sens   = longint'(cal[REG_SENS]);
        c_off    = longint'(cal[REG_OFF]);
        c_tcs    = longint'(cal[REG_TCS]);
        c_tco    = longint'(cal[REG_TCO]);
        c_tref   = longint'(cal[REG_TREF]);
        c_tslope = longint'(cal[REG_TSLOPE]);

        dt   = d2 - c_tref * 256;
        temp = ROOM_CENTI + dt * c_tslope / 8388608;
        off  = c_off * 65536 + c_tco * dt / 128;
        sens = c_sens * 32768 + c_tcs * dt / 256;

        r.cold = temp < ROOM_CENTI;
        if (r.cold) begin
            dev  = temp - ROOM_CENTI;
            aux  = 5 * dev * dev;
            temp = temp - dt * dt / 64'sd2147483648;
            off  = off - aux / 2;
            sens = sens - aux / 4;
        end

        press  = (d1 * sens / 2097152 - off) / 32768;
        tenths = temp / 10;

        r.temp_centi          = temp[TC_W-1:0];
        r.temp_tenths         = tenths[TT_W-1:0];
        r.pressure_centi_mbar = press[PC_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string name,
                                        input logic signed [63:0] want, got);
        if (got !== want) begin
            n_err++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_ALWAYS:  result_if.ready <= 1'b1;
            RX_RANDOM:  result_if.ready <= ($urandom_range(0, 3) != 0);
            RX_PATTERN: result_if.ready <= ((rx_tick % 7) < 3);
            RX_SLOW:    result_if.ready <= ($urandom_range(0, 7) == 0);
            default:    result_if.ready <= 1'b1;
        endcase
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
            n_checked++;
            if (pending_readings.size() == 0) begin
                n_err++;
                $error("result item arrived with no sample pending");
            end else begin
                want = pending_readings.pop_front();
                check_field("temp_centi", 64'(want.temp_centi),
                            64'(result_if.temp_centi));
                check_field("temp_tenths", 64'(want.temp_tenths),
                            64'(result_if.temp_tenths));
                check_field("pressure_centi_mbar", 64'(want.pressure_centi_mbar),
                            64'(result_if.pressure_centi_mbar));
            end
        end
    end

    task automatic send_sample(input logic [RAW_W-1:0] p_raw, t_raw);
        t_reading r;
        sample_if.valid           <= 1'b1;
        sample_if.raw_pressure    <= p_raw;
        sample_if.raw_temperature <= t_raw;
        do @(posedge i_clk); while (sample_if.ready !== 1'b1);
        r = compensate(p_raw, t_raw);
        pending_readings.push_back(r);
        n_sent++;
        if (r.cold) n_cold++;
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0) begin
            sample_if.valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        sample_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx < NUM_REGS) cal[idx] = data;
    endtask

    task automatic program_cal(input logic [COEF_W-1:0] sens, off, tcs, tco, tref, tslope);
        logic [COEF_W-1:0] vals [NUM_REGS];
        vals[REG_SENS]   = sens;
        vals[REG_OFF]    = off;
        vals[REG_TCS]    = tcs;
        vals[REG_TCO]    = tco;
        vals[REG_TREF]   = tref;
        vals[REG_TSLOPE] = tslope;
        for (int i = 0; i < NUM_REGS; i++) begin
            write_reg(CFG_IDX_W'(i), vals[i]);
        end
        write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO,
                  COEF_W'($urandom));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        n_cal_sets++;
    endtask

    task automatic test_reset_calibration();
        send_sample('0, '0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(RAW_W'($urandom), RAW_W'($urandom));
        wait_idle();
    endtask

    task automatic test_datasheet_calibration();
        logic [RAW_W-1:0] t_ref;
        program_cal(16'd40127, 16'd36720, 16'd23308, 16'd23554, 16'd33464, 16'd28312);
        t_ref = RAW_W'(33464 * 256);
        send_sample(24'd9085466, 24'd8569150);
        send_sample(24'd9085466, t_ref);
        hold_off(1);
        send_sample(24'd9085466, t_ref - 24'd296);
        send_sample(24'd9085466, t_ref - 24'd297);
        hold_off(3);
        send_sample('0, '0);
        send_sample(RAW_MAX, '0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample('0, RAW_MAX);
        wait_idle();
    endtask

    task automatic test_calibration_extremes();
        program_cal(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        send_sample(RAW_MAX, '0);
        send_sample('0, RAW_MAX);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample('0, '0);
        send_sample(24'h800000, 24'h7FFFFF);
        wait_idle();

        program_cal(COEF_MAX, '0, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        send_sample(RAW_MAX, '0);
        send_sample('0, '0);
        send_sample(RAW_MAX, 24'hFFFF00);
        wait_idle();

        program_cal('0, COEF_MAX, '0, COEF_MAX, '0, '0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample('0, '0);
        send_sample(24'h555555, 24'hAAAAAA);
        wait_idle();
    endtask

    task automatic test_random_samples();
        int               per_phase, sent, burst;
        longint           base, span, v;
        logic [RAW_W-1:0] p_raw, t_raw;
        per_phase = RANDOM_ITEMS / PHASES;
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase % 2 == 0) begin
                program_cal(COEF_W'($urandom_range(16384, 49151)),
                            COEF_W'($urandom_range(16384, 49151)),
                            COEF_W'($urandom_range(16384, 49151)),
                            COEF_W'($urandom_range(16384, 49151)),
                            COEF_W'($urandom),
                            COEF_W'($urandom_range(16384, 49151)));
            end else begin
                program_cal(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                            COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom));
            end
            sent = 0;
            while (sent < per_phase) begin
                burst   = $urandom_range(1, 24);
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                for (int k = 0; k < burst; k++) begin
                    if (sent < per_phase) begin
                        case ($urandom_range(0, 5))
                            0:       p_raw = '0;
                            1:       p_raw = RAW_MAX;
                            default: p_raw = RAW_W'($urandom);
                        endcase
                        if ($urandom_range(0, 3) == 0) begin
                            t_raw = RAW_W'($urandom);
                        end else begin
                            base = longint'(cal[REG_TREF]);
                            base = base * 256;
                            span = longint'(1) << $urandom_range(2, 20);
                            v    = base - span
                                 + longint'($urandom_range(0, 32'(2 * span)));
                            if (v < 0) v = 0;
                            if (v > longint'(RAW_MAX)) v = longint'(RAW_MAX);
                            t_raw = v[RAW_W-1:0];
                        end
                        send_sample(p_raw, t_raw);
                        sent++;
                        // let the pipeline empty once mid-stream
                        if (phase == PHASES / 2 && sent == per_phase / 2) wait_idle();
                    end
                end
                hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            end
            wait_idle();
        end
        rx_mode = RX_RANDOM;
    endtask

    initial begin
        foreach (cal[i]) cal[i] = '0;
        i_rst_n                   <= 1'b0;
        i_cfg_we                  <= 1'b0;
        i_cfg_idx                 <= '0;
        i_cfg_data                <= '0;
        sample_if.valid           <= 1'b0;
        sample_if.raw_pressure    <= '0;
        sample_if.raw_temperature <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_calibration();
        test_datasheet_calibration();
        test_calibration_extremes();
        test_random_samples();

        wait_idle();
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
        if (pending_readings.size() != 0) begin
            n_err++;
            $error("%0d expected results never arrived", pending_readings.size());
        end

        $display("Checked %0d of %0d samples, %0d of them below 20.00 C,",
                 n_checked, n_sent, n_cold);
        $display("over %0d calibration sets with bursty input and stalled output",
                 n_cal_sets);
        if (n_err == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/bptc_pkg.sv
rtl/core/bptc_in_if.sv
rtl/core/bptc_out_if.sv
rtl/core/bptc_comp.sv
rtl/core/bptc_fin.sv
rtl/core/baro_pressure_temp_compensation.sv
dv/tb.sv
